// ===== sv/rounded_rect_row_span_defines.svh =====
// Assertion macros used by the rounded rectangle row span module
`ifndef ROUNDED_RECT_ROW_SPAN_DEFINES_SVH
`define ROUNDED_RECT_ROW_SPAN_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low
`define RRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrs_pkg.sv =====
// Shared types and constants of the rounded rectangle row span block
package rrs_pkg;

    localparam int PITCH_W     = 15;
    localparam int PIX_PITCH_W = PITCH_W - 2;
    localparam int OFFSET_W    = 26;
    localparam int SPAN_W      = 12;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH       = CFG_IDX_W'(5);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACTOR,
        ST_SQUARE,
        ST_ROOT,
        ST_SPAN,
        ST_FINISH
    } rrs_state_t;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } rrs_unit_status_t;

endpackage

// ===== sv/rrs_if.sv =====
// Row request and span result channel interfaces
interface rrs_row_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] row_index;

    modport source (output valid, output row_index, input ready);
    modport sink (input valid, input row_index, output ready);
endinterface

interface rrs_span_if;
    import rrs_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] pixel_offset;
    logic [SPAN_W-1:0]   span_start;
    logic [SPAN_W-1:0]   span_end;

    modport source (output valid, output pixel_offset, output span_start,
                    output span_end, input ready);
    modport sink (input valid, input pixel_offset, input span_start,
                  input span_end, output ready);
endinterface

// ===== sv/rrs_sqrt.sv =====
// Digit-serial floor square root, one root bit per cycle
module rrs_sqrt #(
    parameter int ROOT_W = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [2*ROOT_W-1:0]         radicand,
    output rrs_pkg::rrs_unit_status_t   status,
    output logic [ROOT_W-1:0]           root
);
    import rrs_pkg::*;

    localparam int RADICAND_W = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int CNT_W      = $clog2(ROOT_W + 1);

    logic [RADICAND_W-1:0] rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W-1:0]     root_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [REM_W+1:0]      rem_shift;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      diff;
    logic                  fits;

    // Bring down the next radicand digit pair and try the next root bit
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[RADICAND_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_shift - trial;
        fits      = (rem_shift >= trial);
        rem_next  = fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
        root_next = {root_reg[ROOT_W-2:0], fits};
    end

    // Count steps and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(ROOT_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Shift the radicand and advance remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RADICAND_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

// ===== sv/rrs_mac.sv =====
// Bit-serial multiply-add, one multiplier bit per cycle
module rrs_mac #(
    parameter int MPLIER_W = 13,
    parameter int MCAND_W  = 13,
    parameter int ACC_W    = 26
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [MPLIER_W-1:0]       mplier,
    input  logic [MCAND_W-1:0]        mcand,
    input  logic [ACC_W-1:0]          addend,
    output rrs_pkg::rrs_unit_status_t status,
    output logic [ACC_W-1:0]          result
);
    import rrs_pkg::*;

    localparam int CNT_W = $clog2(MPLIER_W + 1);

    logic [MPLIER_W-1:0] mplier_reg;
    logic [ACC_W-1:0]    mcand_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    // Add the shifted multiplicand when the current multiplier bit is set
    assign acc_next = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    // Count steps and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(MPLIER_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Shift operands and accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mplier_reg <= mplier;
            mcand_reg  <= ACC_W'(mcand);
            acc_reg    <= addend;
        end
        else if (busy_reg)
        begin
            mplier_reg <= mplier_reg >> 1;
            mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
            acc_reg    <= acc_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = acc_reg;

endmodule

// ===== sv/rounded_rect_row_span.sv =====
// Rounded rectangle row span: framebuffer row offset and fill span per row
//
// Usage: write the six geometry registers through cfg_write/cfg_index/cfg_data
// while the block is idle, then send row requests on the rows channel
// (valid/ready, row_index counted from the rectangle top). Each request gives
// one result on the spans channel: pixel_offset of the row start in the
// framebuffer and the half-open column span [span_start, span_end) relative
// to the rectangle's left edge.
// A new request is taken only once the last result has been loaded into the
// output register. The corner square root, which settles one bit per cycle,
// sets the pace, with the bit-serial row offset multiply running beside it.
// One request is in work at a time.
// Reset clears the geometry registers to zero and empties the output stage.
// If the receiver stalls, the result holds in the output register while the
// next request is taken and worked; that one then waits until the register
// frees up before it is handed over.
`include "rounded_rect_row_span_defines.svh"

module rounded_rect_row_span #(
    parameter int COORD_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    rrs_row_if.sink           rows,
    rrs_span_if.source        spans,
    input  logic              cfg_write,
    input  logic [rrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((COORD_BITS > rrs_pkg::PITCH_W) ? COORD_BITS : rrs_pkg::PITCH_W)-1:0]
                              cfg_data
);
    import rrs_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int RAD_W  = CB - 1;
    localparam int ROOT_W = RAD_W;
    localparam int SUM_W  = CB + 1;
    localparam int DIFF_W = CB + 2;

    // Geometry registers
    logic [CB-1:0]      left_reg;
    logic [CB-1:0]      top_reg;
    logic [CB-1:0]      width_reg;
    logic [CB-1:0]      height_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [PITCH_W-1:0] pitch_reg;

    // Control
    rrs_state_t state_reg;
    rrs_state_t state_next;
    logic       accept;
    logic       sq_start;
    logic       out_load;

    // Request datapath
    logic [CB-1:0]       row;
    logic                in_top;
    logic                in_bot;
    logic [SUM_W-1:0]    bot_sum;
    logic [SUM_W-1:0]    off_next;
    logic [SUM_W-1:0]    off_reg;
    logic                band_reg;
    logic                over;
    logic [RAD_W-1:0]    fac_a_next;
    logic [CB-1:0]       fac_b_next;
    logic [RAD_W-1:0]    fac_a_reg;
    logic [CB-1:0]       fac_b_reg;
    logic [2*CB-2:0]     square;
    logic [SUM_W-1:0]    row_abs;

    // Span datapath
    logic [ROOT_W-1:0]   half;
    logic [CB-1:0]       x0_next;
    logic [DIFF_W-1:0]   x1_next;
    logic [CB-1:0]       x0_reg;
    logic [DIFF_W-1:0]   x1_reg;
    logic [CB-1:0]       end_sel;

    // Serial units
    rrs_unit_status_t    sq_status;
    rrs_unit_status_t    mac_status;
    logic [OFFSET_W-1:0] mac_result;

    // Output stage
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [SPAN_W-1:0]   out_start_reg;
    logic [SPAN_W-1:0]   out_end_reg;

    // Write geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= '0;
            pitch_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RECT_LEFT:   left_reg   <= cfg_data[CB-1:0];
                CFG_RECT_TOP:    top_reg    <= cfg_data[CB-1:0];
                CFG_RECT_WIDTH:  width_reg  <= cfg_data[CB-1:0];
                CFG_RECT_HEIGHT: height_reg <= cfg_data[CB-1:0];
                CFG_RADIUS:      radius_reg <= cfg_data[RAD_W-1:0];
                CFG_PITCH:       pitch_reg  <= cfg_data[PITCH_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequence one request through factor, square, root, span and finish steps
    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        sq_start   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rows.valid)
                begin
                    accept     = 1'b1;
                    state_next = ST_FACTOR;
                end
            end
            ST_FACTOR:
            begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                sq_start   = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sq_status.done)
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (mac_status.done && (!out_valid_reg || spans.ready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign rows.ready = (state_reg == ST_IDLE);

    // Classify the row and take the distance from the corner center
    always_comb
    begin
        row      = rows.row_index;
        in_top   = (row < CB'(radius_reg));
        bot_sum  = SUM_W'(row) + SUM_W'(radius_reg);
        in_bot   = (bot_sum >= SUM_W'(height_reg));
        off_next = in_top ? (SUM_W'(radius_reg) - SUM_W'(row))
                          : (bot_sum - SUM_W'(height_reg));
        row_abs  = SUM_W'(top_reg) + SUM_W'(row);
    end

    // Form radius minus and plus the offset; clamp to zero past the radius
    always_comb
    begin
        over       = (off_reg > SUM_W'(radius_reg));
        fac_a_next = over ? '0 : (radius_reg - off_reg[RAD_W-1:0]);
        fac_b_next = over ? '0 : (CB'(radius_reg) + CB'(off_reg[RAD_W-1:0]));
        square     = fac_a_reg * fac_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            off_reg  <= off_next;
            band_reg <= in_top | in_bot;
        end
        if (state_reg == ST_FACTOR)
        begin
            fac_a_reg <= fac_a_next;
            fac_b_reg <= fac_b_next;
        end
    end

    // Chord half width: root of radius squared minus offset squared
    rrs_sqrt #(
        .ROOT_W   (ROOT_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (square[2*ROOT_W-1:0]),
        .status   (sq_status),
        .root     (half)
    );

    // Row start in pixels: (top + row) * (pitch / 4) + left
    rrs_mac #(
        .MPLIER_W (SUM_W),
        .MCAND_W  (PIX_PITCH_W),
        .ACC_W    (OFFSET_W)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .mplier   (row_abs),
        .mcand    (pitch_reg[PITCH_W-1:2]),
        .addend   (OFFSET_W'(left_reg)),
        .status   (mac_status),
        .result   (mac_result)
    );

    // Narrow the span in a corner band, else span the full width
    always_comb
    begin
        if (band_reg)
        begin
            x0_next = CB'(radius_reg) - CB'(half);
            x1_next = DIFF_W'(width_reg) + DIFF_W'(half) - DIFF_W'(radius_reg);
        end
        else
        begin
            x0_next = '0;
            x1_next = DIFF_W'(width_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SPAN)
        begin
            x0_reg <= x0_next;
            x1_reg <= x1_next;
        end
    end

    // Clamp the end to the start when it falls below it
    always_comb
    begin
        if (x1_reg[DIFF_W-1] || (x1_reg[SUM_W-1:0] < SUM_W'(x0_reg)))
        begin
            end_sel = x0_reg;
        end
        else
        begin
            end_sel = x1_reg[CB-1:0];
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (spans.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_offset_reg <= mac_result;
            out_start_reg  <= SPAN_W'(x0_reg);
            out_end_reg    <= SPAN_W'(end_sel);
        end
    end

    assign spans.valid        = out_valid_reg;
    assign spans.pixel_offset = out_offset_reg;
    assign spans.span_start   = out_start_reg;
    assign spans.span_end     = out_end_reg;

    `RRS_ASSERT_NEXT(a_accept_starts_factor, rows.valid && rows.ready,
        state_reg == ST_FACTOR, "accepted request did not move to factor step")
    `RRS_ASSERT_IMP(a_root_busy_in_root, sq_status.busy,
        state_reg == ST_ROOT, "square root unit busy outside root step")
    `RRS_ASSERT_IMP(a_finish_has_root, state_reg == ST_FINISH,
        sq_status.done, "finish step without a settled square root")
    `RRS_ASSERT_IMP(a_load_has_offset, out_load,
        mac_status.done && !mac_status.busy, "result loaded before row offset settled")

endmodule
